[design/min_primitive_root_finder_core_macros.svh]
// ----------------------------------------------------------------------------
// min_primitive_root_finder_core_macros
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef MIN_PRIMITIVE_ROOT_FINDER_CORE_MACROS_SVH
`define MIN_PRIMITIVE_ROOT_FINDER_CORE_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define MPRF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, always active
`define MPRF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/mprf_pkg.sv]
// ----------------------------------------------------------------------------
// mprf_pkg
// Types and constants for the smallest primitive root finder.
// ----------------------------------------------------------------------------
package mprf_pkg;

  // distinct prime factors of any value below 2^32
  localparam int unsigned MaxFactors = 10;
  localparam int unsigned FacIdxW    = 4;
  localparam int unsigned ModFour    = 4;
  localparam int unsigned RootOfFour = 3;

  typedef enum logic [4:0] {
    S_IDLE,
    S_START,
    S_FCHK,
    S_FRES,
    S_FEND,
    S_PHI,
    S_GCHK,
    S_GCD,
    S_GCDR,
    S_QCHK,
    S_PINIT,
    S_PSTEP,
    S_PACC,
    S_PSQ,
    S_PBASE,
    S_DIV,
    S_DONE
  } state_e;

endpackage

[design/min_primitive_root_finder_core.sv]
// Run time is data dependent: trial division, gcd, and square-and-multiply each
// run many passes of the shared divider.
// Throughput: one transaction at a time; in_ready_o is high only when idle.
// Reset: rst_ni asynchronous active low, returns the sequencer to idle.
// ----------------------------------------------------------------------------
// min_primitive_root_finder_core
// Smallest primitive root modulo n using one shared restoring divider and
// one multiplier under a sequencer.
// ----------------------------------------------------------------------------
module min_primitive_root_finder_core #(
  parameter int unsigned MODULUS_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] modulus_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] root_o,
  output logic        found_o
);

  localparam int unsigned W  = MODULUS_WIDTH;
  localparam int unsigned DW = 2 * W;
  localparam int unsigned CW = $clog2(DW);
  localparam int unsigned FW = mprf_pkg::FacIdxW;

  mprf_pkg::state_e state_q, state_d, ret_q;

  logic [W-1:0]  n_q, m_q, x_q, d_q, p_q, phi_q, g_q, ga_q, gb_q, e_q, acc_q, base_q;
  logic [DW-1:0] sq_q;
  logic [W-1:0]  fac_q [mprf_pkg::MaxFactors];
  logic [FW-1:0] cnt_q, i_q;
  logic          hit_q, phase_q;
  logic [15:0]   root_q;
  logic          found_q;

  logic [DW-1:0] dv_num_q;
  logic [W-1:0]  dv_den_q, dv_rem_q;
  logic [CW-1:0] dv_cnt_q;

  logic [W-1:0]  n_in, m_in;
  logic [W:0]    dv_rem_ext, dv_diff;
  logic          dv_ge, dv_last;
  logic [W-1:0]  dv_rem_nxt;
  logic [W-1:0]  mul_x, mul_y;
  logic [DW-1:0] mul_p;
  logic          fend_app, fend_ok;
  logic [FW-1:0] fend_cnt;
  logic [W-1:0]  fend_first;
  logic          dv_start;
  logic [DW-1:0] dv_num_in;
  logic [W-1:0]  dv_den_in;
  mprf_pkg::state_e dv_ret_in;

  assign n_in = W'(modulus_i);
  assign m_in = n_q[0] ? n_q : (n_q >> 1);

  assign dv_rem_ext = {dv_rem_q, dv_num_q[DW-1]};
  assign dv_diff    = dv_rem_ext - {1'b0, dv_den_q};
  assign dv_ge      = dv_rem_ext >= {1'b0, dv_den_q};
  assign dv_rem_nxt = dv_ge ? dv_diff[W-1:0] : dv_rem_ext[W-1:0];
  assign dv_last    = dv_cnt_q == CW'(DW - 1);

  assign fend_app   = x_q > W'(1);
  assign fend_cnt   = cnt_q + FW'(fend_app);
  assign fend_first = (cnt_q == '0) ? x_q : fac_q[0];
  assign fend_ok    = (fend_cnt == FW'(1)) && (fend_first != W'(2));

  always_comb begin
    unique case (state_q)
      mprf_pkg::S_PSQ: begin
        mul_x = base_q;
        mul_y = base_q;
      end
      mprf_pkg::S_PHI: begin
        mul_x = dv_num_q[W-1:0];
        mul_y = p_q - W'(1);
      end
      default: begin
        mul_x = acc_q;
        mul_y = base_q;
      end
    endcase
  end

  assign mul_p = DW'(mul_x) * DW'(mul_y);

  // divider load select
  always_comb begin
    dv_num_in = dv_num_q;
    dv_den_in = dv_den_q;
    dv_ret_in = ret_q;
    unique case (state_q)
      mprf_pkg::S_FCHK: begin
        dv_num_in = DW'(x_q);
        dv_den_in = d_q;
        dv_ret_in = mprf_pkg::S_FRES;
      end
      mprf_pkg::S_FRES: begin
        dv_num_in = dv_num_q;
        dv_den_in = d_q;
        dv_ret_in = mprf_pkg::S_FRES;
      end
      mprf_pkg::S_FEND: begin
        dv_num_in = DW'(m_q);
        dv_den_in = fend_first;
        dv_ret_in = mprf_pkg::S_PHI;
      end
      mprf_pkg::S_GCD: begin
        dv_num_in = DW'(ga_q);
        dv_den_in = gb_q;
        dv_ret_in = mprf_pkg::S_GCDR;
      end
      mprf_pkg::S_QCHK: begin
        dv_num_in = DW'(phi_q);
        dv_den_in = fac_q[i_q];
        dv_ret_in = mprf_pkg::S_PINIT;
      end
      mprf_pkg::S_PSTEP: begin
        dv_num_in = mul_p;
        dv_den_in = n_q;
        dv_ret_in = mprf_pkg::S_PACC;
      end
      mprf_pkg::S_PSQ: begin
        dv_num_in = mul_p;
        dv_den_in = n_q;
        dv_ret_in = mprf_pkg::S_PBASE;
      end
      default: ;
    endcase
  end

  assign dv_start = (state_d == mprf_pkg::S_DIV) && (state_q != mprf_pkg::S_DIV);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mprf_pkg::S_IDLE: if (in_valid_i) state_d = mprf_pkg::S_START;
      mprf_pkg::S_START: begin
        if (n_q == W'(2) || n_q == W'(mprf_pkg::ModFour) || n_q < W'(2) || m_in < W'(2)) begin
          state_d = mprf_pkg::S_DONE;
        end else begin
          state_d = mprf_pkg::S_FCHK;
        end
      end
      mprf_pkg::S_FCHK:
        state_d = (sq_q <= DW'(x_q)) ? mprf_pkg::S_DIV : mprf_pkg::S_FEND;
      mprf_pkg::S_FRES:
        state_d = (dv_rem_q == '0) ? mprf_pkg::S_DIV : mprf_pkg::S_FCHK;
      mprf_pkg::S_FEND: begin
        if (phase_q) begin
          state_d = mprf_pkg::S_GCHK;
        end else begin
          state_d = fend_ok ? mprf_pkg::S_DIV : mprf_pkg::S_DONE;
        end
      end
      mprf_pkg::S_PHI:  state_d = mprf_pkg::S_FCHK;
      mprf_pkg::S_GCHK: state_d = (g_q >= n_q) ? mprf_pkg::S_DONE : mprf_pkg::S_GCD;
      mprf_pkg::S_GCD: begin
        if (gb_q == '0) begin
          state_d = (ga_q == W'(1)) ? mprf_pkg::S_QCHK : mprf_pkg::S_GCHK;
        end else begin
          state_d = mprf_pkg::S_DIV;
        end
      end
      mprf_pkg::S_GCDR:  state_d = mprf_pkg::S_GCD;
      mprf_pkg::S_QCHK:  state_d = (i_q == cnt_q) ? mprf_pkg::S_DONE : mprf_pkg::S_DIV;
      mprf_pkg::S_PINIT: state_d = mprf_pkg::S_PSTEP;
      mprf_pkg::S_PSTEP: begin
        if (e_q == '0) begin
          state_d = (acc_q == W'(1)) ? mprf_pkg::S_GCHK : mprf_pkg::S_QCHK;
        end else begin
          state_d = e_q[0] ? mprf_pkg::S_DIV : mprf_pkg::S_PSQ;
        end
      end
      mprf_pkg::S_PACC:  state_d = mprf_pkg::S_PSQ;
      mprf_pkg::S_PSQ:   state_d = mprf_pkg::S_DIV;
      mprf_pkg::S_PBASE: state_d = mprf_pkg::S_PSTEP;
      mprf_pkg::S_DIV:   state_d = dv_last ? ret_q : mprf_pkg::S_DIV;
      mprf_pkg::S_DONE:  if (out_ready_i) state_d = mprf_pkg::S_IDLE;
      default:           state_d = mprf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mprf_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (dv_start) begin
      dv_num_q <= dv_num_in;
      dv_den_q <= dv_den_in;
      dv_rem_q <= '0;
      dv_cnt_q <= '0;
      ret_q    <= dv_ret_in;
    end
    unique case (state_q)
      mprf_pkg::S_IDLE: if (in_valid_i) n_q <= n_in;
      mprf_pkg::S_START: begin
        m_q     <= m_in;
        x_q     <= m_in;
        d_q     <= W'(2);
        sq_q    <= DW'(4);
        cnt_q   <= '0;
        hit_q   <= 1'b0;
        phase_q <= 1'b0;
        if (n_q == W'(2)) begin
          root_q  <= 16'd1;
          found_q <= 1'b1;
        end else if (n_q == W'(mprf_pkg::ModFour)) begin
          root_q  <= 16'(mprf_pkg::RootOfFour);
          found_q <= 1'b1;
        end else begin
          root_q  <= '0;
          found_q <= 1'b0;
        end
      end
      mprf_pkg::S_FRES: begin
        if (dv_rem_q == '0) begin
          x_q <= dv_num_q[W-1:0];
          if (!hit_q) begin
            fac_q[cnt_q] <= d_q;
            cnt_q        <= cnt_q + FW'(1);
            hit_q        <= 1'b1;
          end
        end else begin
          d_q   <= d_q + W'(1);
          sq_q  <= sq_q + DW'({d_q, 1'b1});
          hit_q <= 1'b0;
        end
      end
      mprf_pkg::S_FEND: begin
        if (fend_app) fac_q[cnt_q] <= x_q;
        cnt_q <= fend_cnt;
        p_q   <= fend_first;
        g_q   <= W'(1);
      end
      mprf_pkg::S_PHI: begin
        phi_q   <= mul_p[W-1:0];
        x_q     <= mul_p[W-1:0];
        phase_q <= 1'b1;
        cnt_q   <= '0;
        d_q     <= W'(2);
        sq_q    <= DW'(4);
        hit_q   <= 1'b0;
      end
      mprf_pkg::S_GCHK: begin
        ga_q <= n_q;
        gb_q <= g_q;
      end
      mprf_pkg::S_GCD: begin
        if (gb_q == '0) begin
          if (ga_q == W'(1)) begin
            i_q <= '0;
          end else begin
            g_q <= g_q + W'(1);
          end
        end
      end
      mprf_pkg::S_GCDR: begin
        ga_q <= gb_q;
        gb_q <= dv_rem_q;
      end
      mprf_pkg::S_QCHK: begin
        if (i_q == cnt_q) begin
          root_q  <= 16'(g_q);
          found_q <= 1'b1;
        end
      end
      mprf_pkg::S_PINIT: begin
        e_q    <= dv_num_q[W-1:0];
        acc_q  <= W'(1);
        base_q <= g_q;
      end
      mprf_pkg::S_PSTEP: begin
        if (e_q == '0) begin
          if (acc_q == W'(1)) begin
            g_q <= g_q + W'(1);
          end else begin
            i_q <= i_q + FW'(1);
          end
        end
      end
      mprf_pkg::S_PACC: acc_q <= dv_rem_q;
      mprf_pkg::S_PBASE: begin
        base_q <= dv_rem_q;
        e_q    <= e_q >> 1;
      end
      mprf_pkg::S_DIV: begin
        dv_num_q <= {dv_num_q[DW-2:0], dv_ge};
        dv_rem_q <= dv_rem_nxt;
        dv_cnt_q <= dv_cnt_q + CW'(1);
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = state_q == mprf_pkg::S_IDLE;
    out_valid_o = state_q == mprf_pkg::S_DONE;
  end

  assign root_o  = root_q;
  assign found_o = found_q;

endmodule

[design/mprf_checker.sv]
// ----------------------------------------------------------------------------
// mprf_checker
// Port-level checks for the smallest primitive root finder.
// ----------------------------------------------------------------------------
`include "min_primitive_root_finder_core_macros.svh"

module mprf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] root_o,
  input logic        found_o
);

  `MPRF_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped while stalled")
  `MPRF_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i |=> $stable(root_o) && $stable(found_o), "result changed while stalled")
  `MPRF_ASSERT(a_nf_zero, clk_i, rst_ni, out_valid_o && !found_o |-> root_o == 16'd0, "nonzero root without found")
  `MPRF_ASSERT(a_one_at_a_time, clk_i, rst_ni, out_valid_o |-> !in_ready_o, "ready while a result is pending")
  `MPRF_ASSERT(a_no_instant, clk_i, rst_ni, in_valid_i && in_ready_o |=> !out_valid_o && !in_ready_o, "transaction finished too early")

endmodule

bind min_primitive_root_finder_core mprf_checker u_mprf_checker (.*);

[sim/tb_min_primitive_root_finder_core.sv]
// ----------------------------------------------------------------------------
// tb_min_primitive_root_finder_core
// Self-checking bench for the smallest primitive root finder. A queue-fed
// driver offers moduli with random gaps, and a monitor with random stalls
// compares each result against an in-bench root search.
// ----------------------------------------------------------------------------
module tb_min_primitive_root_finder_core;

  typedef struct packed {
    logic [15:0] root;
    logic        found;
  } root_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] modulus_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] root_o;
  logic        found_o;

  logic [15:0] moduli_q[$];
  root_res_t   roots_q[$];
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_cnt = 0;
  int unsigned outs_seen = 0;
  bit          hold_done = 1'b0;
  int unsigned errors = 0;

  always #2 clk_i = ~clk_i;

  min_primitive_root_finder_core #(
    .MODULUS_WIDTH(16)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .modulus_i  (modulus_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .root_o     (root_o),
    .found_o    (found_o)
  );

  function automatic longint unsigned mod_pow(longint unsigned b, longint unsigned e,
                                              longint unsigned m);
    longint unsigned acc;
    acc = 1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) acc = (acc * b) % m;
      b = (b * b) % m;
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic void distinct_primes(longint unsigned x, ref longint unsigned fac[$]);
    longint unsigned d;
    fac.delete();
    for (d = 2; d * d <= x; d++) begin
      if (x % d == 0) begin
        while (x % d == 0) x = x / d;
        fac = {fac, d};
      end
    end
    if (x > 1) fac = {fac, x};
  endfunction

  function automatic root_res_t predict_root(logic [15:0] modulus);
    longint unsigned n, m, ph, g;
    longint unsigned fac[$];
    root_res_t res;
    bit exists, ok;
    n = modulus;
    res = '0;
    if (n == 2 || n == 4) exists = 1'b1;
    else if (n < 2) exists = 1'b0;
    else begin
      m = (n % 2 == 0) ? n / 2 : n;
      if (m < 2) exists = 1'b0;
      else begin
        distinct_primes(m, fac);
        exists = (fac.size() == 1) && (fac[0] != 2);
      end
    end
    if (!exists) return res;
    ph = n;
    distinct_primes(n, fac);
    foreach (fac[i]) ph = ph / fac[i] * (fac[i] - 1);
    distinct_primes(ph, fac);
    for (g = 1; g < n; g++) begin
      if (gcd_of(g, n) != 1) continue;
      ok = 1'b1;
      foreach (fac[i]) begin
        if (mod_pow(g, ph / fac[i], n) == 1) begin
          ok = 1'b0;
          break;
        end
      end
      if (ok) begin
        res.root = g[15:0];
        res.found = 1'b1;
        return res;
      end
    end
    return res;
  endfunction

  function automatic int unsigned draw_gap();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) roots_q = {roots_q, predict_root(modulus_i)};
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (moduli_q.size() > 0) begin
          in_valid_i <= 1'b1;
          modulus_i <= moduli_q.pop_front();
          send_gap <= draw_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    root_res_t exp_res;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        outs_seen <= outs_seen + 1;
        if (roots_q.size() == 0) begin
          $display("%0t: unexpected transaction root=%0d found=%0b", $time, root_o, found_o);
          errors = errors + 1;
        end else begin
          exp_res = roots_q.pop_front();
          if (root_o !== exp_res.root) begin
            $display("%0t: root mismatch expected %0d actual %0d", $time, exp_res.root, root_o);
            errors = errors + 1;
          end
          if (found_o !== exp_res.found) begin
            $display("%0t: found mismatch expected %0b actual %0b", $time, exp_res.found,
                     found_o);
            errors = errors + 1;
          end
        end
      end
      if (!hold_done && outs_seen == 20) begin
        hold_done <= 1'b1;
        hold_cnt <= 3000;
        out_ready_i <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (out_valid_o && out_ready_i) recv_gap <= draw_gap();
      end
    end
  end

  initial begin
    logic [15:0] pp[$];
    int unsigned sel;
    int unsigned total;
    pp = '{3, 5, 7, 9, 11, 13, 25, 27, 49, 81, 121, 125, 169, 243, 289, 343};
    moduli_q = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7, 16'd8, 16'd9,
                 16'd10, 16'd12, 16'd18, 16'd25, 16'd27, 16'd50, 16'd54, 16'd98,
                 16'd32768, 16'd65535, 16'd65521, 16'd65498, 16'd43690, 16'd21845};
    repeat (125) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) moduli_q = {moduli_q, 16'($urandom_range(0, 600))};
      else if (sel < 8) begin
        moduli_q = {moduli_q, 16'(pp[$urandom_range(0, pp.size() - 1)] << $urandom_range(0, 1))};
      end else moduli_q = {moduli_q, 16'($urandom_range(0, 65535))};
    end
    total = moduli_q.size();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i);
    while (outs_seen != total);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && roots_q.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #2000000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/mprf_pkg.sv
design/min_primitive_root_finder_core.sv
design/mprf_checker.sv
sim/tb_min_primitive_root_finder_core.sv
